@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl that checks itself
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CBM_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen outside reset
`define CBM_ASSERT_NEVER(lbl, expr, msg) \
    `CBM_ASSERT_CLK(lbl, !(expr), msg)

`endif

@@ rtl/cbm_pkg.sv @@
// shared types and constants of the color boundary marker
// no dependencies
`default_nettype none

package cbm_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT_ENABLE = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic             RST_HIGHLIGHT    = 1'b1;

    // result kinds of one input pixel, in emission order
    localparam int RES_ABOVE = 0;
    localparam int RES_LEFT  = 1;
    localparam int RES_LAST  = 2;
    localparam int RES_KINDS = 3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // classified pixel handed from front to back
    typedef struct packed {
        logic             have_above;
        logic             have_left;
        logic             have_last;
        logic             mark_above;
        logic             mark_left;
        t_rgb             above_px;
        t_rgb             left_px;
        t_rgb             cur_px;
        logic [ROW_W-1:0] row;
    } t_qinfo;

endpackage

`default_nettype wire

@@ rtl/cbm_pix_if.sv @@
// valid/ready channel carrying one input rgb pixel
// no dependencies
`default_nettype none

interface cbm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/cbm_res_if.sv @@
// valid/ready channel carrying one marked result pixel with its position
// no dependencies
`default_nettype none

interface cbm_res_if #(
    parameter int COL_W = 11,
    parameter int ROW_W = 12
);
    logic             valid;
    logic             ready;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic             boundary;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic             frame_end;
    logic             run_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output boundary, output pixel_row, output pixel_col,
                    output frame_end, output run_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input boundary, input pixel_row, input pixel_col,
                    input frame_end, input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/cbm_queue.sv @@
// small register queue between the classifying front and the emitting back
// depends on cbm_pkg
`default_nettype none

module cbm_queue import cbm_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointer wrap for any depth
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= n_wr_ptr;
            if (i_pop)  r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

@@ rtl/cbm_front.sv @@
// front end: accepts pixels, tracks position, keeps the line store, classifies
// depends on cbm_pkg and cbm_pix_if
`default_nettype none

module cbm_front import cbm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int CMP_W     = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CMP_W-1:0] i_width,
    input  wire logic [ROW_W-1:0] i_height,
    input  wire logic             i_enable,
    cbm_pix_if.sink               i_pix,
    output logic                  o_q_push,
    output t_qinfo                o_q_info,
    output logic [COL_W-1:0]      o_q_col,
    input  wire logic             i_q_full
);

    // line store, previous row of the frame
    t_rgb r_line [MAX_WIDTH];
    t_rgb r_rd;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_rgb             r_prev;
    t_rgb             r_above;

    // stage one holding register
    logic             r_s1_valid;
    t_rgb             r_s1_pix;
    t_rgb             r_s1_prev;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_have_above;
    logic             r_s1_have_left;
    logic             r_s1_have_last;
    logic             r_s1_has_right;
    logic             r_s1_en;

    logic             accept;
    logic             s1_any;
    logic             s1_adv;
    logic             restart;
    t_rgb             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CMP_W-1:0] col_inc;
    logic             last_col;
    logic             last_row;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             diff_above;

    assign pix = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};

    // position of this pixel; a count at or beyond the frame size starts a new frame
    always_comb begin
        restart  = (CMP_W'(r_col) >= i_width) || (r_row >= i_height);
        col      = restart ? '0 : r_col;
        row      = restart ? '0 : r_row;
        col_inc  = CMP_W'(col) + CMP_W'(1);
        last_col = (col_inc == i_width);
        last_row = (row == i_height - ROW_W'(1));
        // prefetch next column above; at row end this is column zero of this row
        rd_addr  = last_col ? '0 : col_inc[COL_W-1:0];
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row + ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = row;
        end
    end

    // handshake and queue push
    assign s1_any   = r_s1_have_above || r_s1_have_left || r_s1_have_last;
    assign s1_adv   = !r_s1_valid || !s1_any || !i_q_full;
    assign accept   = i_pix.valid && s1_adv;
    assign i_pix.ready = s1_adv;
    assign o_q_push = r_s1_valid && s1_any && !i_q_full;

    // line store write and registered read, bypass when both hit one entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line[col] <= pix;
            if (rd_addr == col) r_rd <= pix;
            else                r_rd <= r_line[rd_addr];
        end
    end

    // position counters and stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_prev     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_prev     <= pix;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage one payload; the prefetched pixel becomes the next pixel above
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix        <= pix;
            r_s1_prev       <= r_prev;
            r_s1_col        <= col;
            r_s1_row        <= row;
            r_s1_have_above <= (row != '0);
            r_s1_have_left  <= last_row && (col != '0);
            r_s1_have_last  <= last_row && last_col;
            r_s1_has_right  <= !last_col;
            r_s1_en         <= i_enable;
        end
        if (r_s1_valid && s1_adv) r_above <= r_rd;
    end

    // neighbor compares
    assign diff_above = (r_s1_pix != r_above) || (r_s1_has_right && (r_rd != r_above));

    always_comb begin
        o_q_info.have_above = r_s1_have_above;
        o_q_info.have_left  = r_s1_have_left;
        o_q_info.have_last  = r_s1_have_last;
        o_q_info.mark_above = r_s1_en && diff_above;
        o_q_info.mark_left  = r_s1_en && (r_s1_prev != r_s1_pix);
        o_q_info.above_px   = r_above;
        o_q_info.left_px    = r_s1_prev;
        o_q_info.cur_px     = r_s1_pix;
        o_q_info.row        = r_s1_row;
        o_q_col             = r_s1_col;
    end

endmodule

`default_nettype wire

@@ rtl/cbm_back.sv @@
// back end: expands each queued pixel into its results and drives the output
// depends on cbm_pkg and cbm_res_if
`default_nettype none

module cbm_back import cbm_pkg::*; #(
    parameter int COL_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire t_qinfo           i_q_info,
    input  wire logic [COL_W-1:0] i_q_col,
    output logic                  o_q_pop,
    cbm_res_if.source             o_res
);

    logic                 r_valid;
    logic [RES_KINDS-1:0] r_done;
    t_rgb                 r_px;
    logic                 r_mark;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic                 r_fend;
    logic                 r_last;

    logic [RES_KINDS-1:0] pending;
    logic [RES_KINDS-1:0] sel;
    logic                 last;
    logic                 load;
    t_rgb                 n_px;
    logic                 n_mark;
    logic [ROW_W-1:0]     n_row;
    logic [COL_W-1:0]     n_col;
    logic                 n_fend;

    // results of the head entry not yet sent, take the earliest
    always_comb begin
        pending            = '0;
        pending[RES_ABOVE] = i_q_info.have_above;
        pending[RES_LEFT]  = i_q_info.have_left;
        pending[RES_LAST]  = i_q_info.have_last;
        pending            = pending & ~r_done;
        sel                = pending & (~pending + RES_KINDS'(1));
        last               = ((pending & ~sel) == '0);
    end

    assign load    = !i_q_empty && (!r_valid || o_res.ready);
    assign o_q_pop = load && last;

    // build the selected result
    always_comb begin
        n_px   = i_q_info.cur_px;
        n_mark = 1'b0;
        n_row  = i_q_info.row;
        n_col  = i_q_col;
        n_fend = 1'b0;
        priority if (sel[RES_ABOVE]) begin
            n_px   = i_q_info.mark_above ? '0 : i_q_info.above_px;
            n_mark = i_q_info.mark_above;
            n_row  = i_q_info.row - ROW_W'(1);
        end else if (sel[RES_LEFT]) begin
            n_px   = i_q_info.mark_left ? '0 : i_q_info.left_px;
            n_mark = i_q_info.mark_left;
            n_col  = i_q_col - COL_W'(1);
        end else begin
            n_fend = 1'b1;
        end
    end

    // output register valid and progress through the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last ? '0 : (r_done | sel);
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= n_px;
            r_mark <= n_mark;
            r_row  <= n_row;
            r_col  <= n_col;
            r_fend <= n_fend;
            r_last <= last;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.out_red   = r_px.red;
    assign o_res.out_green = r_px.green;
    assign o_res.out_blue  = r_px.blue;
    assign o_res.boundary  = r_mark;
    assign o_res.pixel_row = r_row;
    assign o_res.pixel_col = r_col;
    assign o_res.frame_end = r_fend;
    assign o_res.run_last  = r_last;

endmodule

`default_nettype wire

@@ rtl/color_boundary_marking_top.sv @@
// color boundary marker top: config registers, front, queue and back
// a pixel passes stage one of the front, the queue and the back output register
// throughput: one pixel per cycle unless the queue fills; last-row pixels give up
//   to two results and the final pixel up to three, via the one output register
// reset: synchronous active low clears config, counters and queue; line store unreset
`default_nettype none
`include "assert_macros.svh"

module color_boundary_marking_top import cbm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    cbm_pix_if.sink                   i_pix,
    cbm_res_if.source                 o_res
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WW > CFG_W) ? WW : CFG_W;
    localparam int QDATA_W = $bits(t_qinfo) + COL_W;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             r_highlight;

    logic [CMP_W-1:0] fw_ext;
    logic [CMP_W-1:0] eff_width;
    logic [ROW_W-1:0] eff_height;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    t_qinfo             q_in_info;
    t_qinfo             q_out_info;
    logic [COL_W-1:0]   q_in_col;
    logic [COL_W-1:0]   q_out_col;
    logic [QDATA_W-1:0] q_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_highlight    <= RST_HIGHLIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:      r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT:     r_frame_height <= i_cfg_data;
                CFG_HIGHLIGHT_ENABLE: r_highlight    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero acts as one, width saturates at the store depth
    always_comb begin
        fw_ext = CMP_W'(r_frame_width);
        priority if (fw_ext == '0)                  eff_width = CMP_W'(1);
        else if (fw_ext > CMP_W'(MAX_WIDTH))        eff_width = CMP_W'(MAX_WIDTH);
        else                                        eff_width = fw_ext;
        eff_height = (r_frame_height == '0) ? ROW_W'(1) : r_frame_height;
    end

    cbm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .CMP_W     (CMP_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (eff_width),
        .i_height (eff_height),
        .i_enable (r_highlight),
        .i_pix    (i_pix),
        .o_q_push (q_push),
        .o_q_info (q_in_info),
        .o_q_col  (q_in_col),
        .i_q_full (q_full)
    );

    cbm_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_in_col, q_in_info}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_empty (q_empty)
    );

    assign q_out_info = q_out_data[$bits(t_qinfo)-1:0];
    assign q_out_col  = q_out_data[QDATA_W-1:$bits(t_qinfo)];

    cbm_back #(
        .COL_W (COL_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_info  (q_out_info),
        .i_q_col   (q_out_col),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    // checks
    `CBM_ASSERT_NEVER(a_q_overflow, q_push && q_full, "queue push while full")
    `CBM_ASSERT_NEVER(a_q_underflow, q_pop && q_empty, "queue pop while empty")
    `CBM_ASSERT_CLK(a_mark_black, (o_res.valid && o_res.boundary) |-> (o_res.out_red == 8'd0 && o_res.out_green == 8'd0 && o_res.out_blue == 8'd0), "marked pixel not black")
    `CBM_ASSERT_CLK(a_fend_last, (o_res.valid && o_res.frame_end) |-> (o_res.run_last && !o_res.boundary), "frame end result malformed")

endmodule

`default_nettype wire

@@ test/tb_color_boundary_marking_top.sv @@
`timescale 1ns / 1ps
// testbench for color_boundary_marking_top: drives raster rgb frames under several
// frame sizes and checks every result against a built-in line-buffer predictor
// depends on cbm_pkg, cbm_pix_if, cbm_res_if and the top level of the rtl

module tb_color_boundary_marking_top;
    import cbm_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 420;
    localparam int SETTLE_CYCLES = 8;

    // one emitted pixel as the block should present it
    typedef struct packed {
        t_rgb             px;
        logic             boundary;
        logic [ROW_W-1:0] row;
        logic [10:0]      col;
        logic             frame_end;
        logic             run_last;
    } mark_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    cbm_pix_if pix_ch ();
    cbm_res_if res_ch ();

    color_boundary_marking_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    // shadow of the configuration registers
    logic [CFG_W-1:0] cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    logic             cfg_enable = RST_HIGHLIGHT;

    // predictor state: previous row, previous pixel and raster position
    t_rgb        line_buf [MAX_WIDTH_DEF];
    bit          line_valid [MAX_WIDTH_DEF];
    t_rgb        left_px = '0;
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    t_rgb  pixels_to_send [$];
    mark_t pending_marks [$];

    bit          pix_took = 1'b0;
    bit          res_took = 1'b0;
    bit          failed = 1'b0;
    int unsigned gap_odds = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    // directed frames: size, highlight and pixel count per step
    int          dir_w [7] = '{3, 0, 2, 4095, 2, 2, 2};
    int          dir_h [7] = '{3, 0, 2, 1, 1, 4095, 1};
    bit          dir_en [7] = '{1, 1, 0, 1, 1, 1, 1};
    int          dir_n [7] = '{9, 2, 4, 3, 2, 4, 2};
    logic [23:0] dir_px [26] = '{
        24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF,
        24'hFF00FF, 24'hFF00FF, 24'hFFFF00,
        24'h000000, 24'hFFFFFF,
        24'h123456, 24'h654321, 24'h123456, 24'hABCDEF,
        24'h0000FF, 24'h0000FF, 24'h00FF00,
        24'h808080, 24'h7F7F7F,
        24'h00FF00, 24'h00FF00, 24'h00FF00, 24'hFF0000,
        24'hFFFFFF, 24'hFFFFFF
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned frame_cols(input logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return raw;
    endfunction

    function automatic int unsigned frame_rows(input logic [CFG_W-1:0] raw);
        return (raw == 0) ? 1 : raw;
    endfunction

    // a size change must never make the current row read a line entry never written
    function automatic bit store_ready(input int unsigned w, input int unsigned h);
        if (col_cnt >= w || row_cnt >= h || row_cnt == 0) return 1'b1;
        for (int unsigned i = col_cnt; i < w; i++) begin
            if (!line_valid[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic mark_t make_mark(input t_rgb px, input logic blacken,
                                        input int unsigned r, input int unsigned c,
                                        input logic last_px);
        mark_t m;
        m.px        = blacken ? '0 : px;
        m.boundary  = blacken;
        m.row       = ROW_W'(r);
        m.col       = 11'(c);
        m.frame_end = last_px;
        m.run_last  = 1'b0;
        return m;
    endfunction

    // results caused by one accepted pixel, in emission order
    task automatic mark_pixel(input t_rgb px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        t_rgb        up;
        logic        differs;
        mark_t       hits [$];
        w = frame_cols(cfg_width);
        h = frame_rows(cfg_height);
        c = col_cnt;
        r = row_cnt;
        // size shrank under the raster position: start a new frame
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        // pixel above is now complete: compare with below and its right neighbor
        if (r >= 1) begin
            up = line_buf[c];
            differs = (px != up) || (c + 1 < w && line_buf[c + 1] != up);
            hits.push_back(make_mark(up, cfg_enable && differs, r - 1, c, 1'b0));
        end
        // last row only compares left to right
        if (r == h - 1) begin
            if (c >= 1) begin
                hits.push_back(make_mark(left_px, cfg_enable && (left_px != px),
                                         r, c - 1, 1'b0));
            end
            if (c == w - 1) begin
                hits.push_back(make_mark(px, 1'b0, r, c, 1'b1));
            end
        end
        line_buf[c]   = px;
        line_valid[c] = 1'b1;
        left_px       = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
        if (hits.size() > 0) hits[hits.size() - 1].run_last = 1'b1;
        foreach (hits[i]) pending_marks.push_back(hits[i]);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH: cfg_width = value;
            CFG_FRAME_HEIGHT: cfg_height = value;
            CFG_HIGHLIGHT_ENABLE: cfg_enable = value[0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input bit en);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_HIGHLIGHT_ENABLE, CFG_W'(en));
    endtask

    // wait until every pixel is sent and every result is back, then let the pipe empty
    task automatic settle();
        while (pixels_to_send.size() != 0 || pix_ch.valid || pending_marks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // pixel driver: holds a pixel until its transfer, with random idle bursts
    always @(negedge i_clk) begin
        t_rgb nxt;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_took) begin
            if (send_gap > 0) begin
                send_gap--;
                pix_ch.valid <= 1'b0;
            end else if (pixels_to_send.size() == 0) begin
                pix_ch.valid <= 1'b0;
            end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                send_gap = $urandom_range(0, 7);
                pix_ch.valid <= 1'b0;
            end else begin
                nxt = pixels_to_send.pop_front();
                pix_ch.valid    <= 1'b1;
                pix_ch.in_red   <= nxt.red;
                pix_ch.in_green <= nxt.green;
                pix_ch.in_blue  <= nxt.blue;
            end
        end
    end

    // result ready with random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            stall_left = $urandom_range(0, 7);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // monitor: check result transfers, predict from pixel transfers, watchdog
    always @(posedge i_clk) begin
        mark_t want;
        pix_took = i_rst_n && pix_ch.valid && pix_ch.ready;
        res_took = i_rst_n && res_ch.valid && res_ch.ready;
        if (res_took) begin
            if (pending_marks.size() == 0) begin
                $error("unexpected result transfer at row %0d col %0d",
                       res_ch.pixel_row, res_ch.pixel_col);
                failed = 1'b1;
            end else begin
                want = pending_marks.pop_front();
                check_field("out_red", want.px.red, res_ch.out_red);
                check_field("out_green", want.px.green, res_ch.out_green);
                check_field("out_blue", want.px.blue, res_ch.out_blue);
                check_field("boundary", want.boundary, res_ch.boundary);
                check_field("pixel_row", want.row, res_ch.pixel_row);
                check_field("pixel_col", want.col, res_ch.pixel_col);
                check_field("frame_end", want.frame_end, res_ch.frame_end);
                check_field("run_last", want.run_last, res_ch.run_last);
            end
        end
        if (pix_took) mark_pixel({pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue});
        if (!i_rst_n || pix_took || res_took) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_color_boundary_marking_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int unsigned      k;
        int unsigned      random_sent;
        int unsigned      w;
        int unsigned      h;
        int unsigned      done;
        int unsigned      count;
        int unsigned      sel;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        t_rgb             palette [3];
        t_rgb             px;

        pix_ch.valid    = 1'b0;
        pix_ch.in_red   = '0;
        pix_ch.in_green = '0;
        pix_ch.in_blue  = '0;
        res_ch.ready    = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames: extremes, one-channel differences, degenerate and
        // saturated sizes, highlight off, and size shrinks in the middle of a frame
        gap_odds = 4;
        k = 0;
        for (int s = 0; s < 7; s++) begin
            set_frame(CFG_W'(dir_w[s]), CFG_W'(dir_h[s]), dir_en[s]);
            repeat (dir_n[s]) begin
                pixels_to_send.push_back(dir_px[k]);
                k++;
            end
            settle();
        end

        // random frames, mostly complete ones from a small palette
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent > RANDOM_PIXELS - 60) gap_odds = 0;
            else gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);

            case ($urandom_range(0, 9))
                0: new_w = '0;
                1: new_w = CFG_W'($urandom_range(MAX_WIDTH_DEF, 4095));
                2: new_w = CFG_W'($urandom_range(9, 24));
                default: new_w = CFG_W'($urandom_range(1, 8));
            endcase
            if (frame_cols(new_w) > 64) begin
                new_h = CFG_W'($urandom_range(0, 1));
            end else begin
                case ($urandom_range(0, 9))
                    0: new_h = '0;
                    1: new_h = CFG_W'($urandom_range(7, 4095));
                    default: new_h = CFG_W'($urandom_range(1, 6));
                endcase
            end
            // a one-row height forces a restart and so never reads stale line entries
            if (!store_ready(frame_cols(new_w), frame_rows(new_h))) new_h = CFG_W'(1);
            set_frame(new_w, new_h, $urandom_range(0, 3) != 0);

            w = frame_cols(cfg_width);
            h = frame_rows(cfg_height);
            if (w * h <= 48) begin
                done  = (col_cnt >= w || row_cnt >= h) ? 0 : row_cnt * w + col_cnt;
                count = w * h - done + $urandom_range(0, 2) * w * h;
                // broken frame now and then
                if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
            end else begin
                count = $urandom_range(1, 24);
            end

            palette[0] = t_rgb'($urandom);
            palette[1] = palette[0] ^ (24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2)));
            palette[2] = t_rgb'($urandom);
            repeat (count) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) px = t_rgb'($urandom);
                else if (sel <= 4) px = palette[0];
                else if (sel <= 6) px = palette[1];
                else px = palette[2];
                pixels_to_send.push_back(px);
            end
            random_sent += count;
            settle();
        end

        if (pending_marks.size() != 0) begin
            $error("%0d expected results never arrived", pending_marks.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("tb_color_boundary_marking_top OK");
        end else begin
            $display("tb_color_boundary_marking_top NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_pix_if.sv
rtl/cbm_res_if.sv
rtl/cbm_queue.sv
rtl/cbm_front.sv
rtl/cbm_back.sv
rtl/color_boundary_marking_top.sv
test/tb_color_boundary_marking_top.sv
